// File: hw/rtl/soy2cal_pkg.sv
// Shared types and constants for the second-of-year to calendar converter.
// No dependencies; the top level and soy2cal_month import this package.
package soy2cal_pkg;

    // One input item: year, second within that year, microsecond.
    typedef struct packed {
        logic [13:0] year_in;
        logic [24:0] second_of_year;
        logic [19:0] microsecond_in;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [13:0] year_out;
        logic [8:0]  day_of_year;
        logic [3:0]  month_number;
        logic [4:0]  day_of_month;
        logic [4:0]  hour_of_day;
        logic [5:0]  minute_of_hour;
        logic [5:0]  second_of_minute;
        logic [19:0] microsecond_out;
        logic        invalid;
    } t_out_item;

    // Stage enables handed to the month lookup.
    typedef struct packed {
        logic cmp_en;
        logic sel_en;
    } t_mon_ctl;

    localparam int SECS_PER_MIN  = 60;
    localparam int MINS_PER_HOUR = 60;
    localparam int HOURS_PER_DAY = 24;
    localparam int LEAP_DIVISOR  = 25;
    localparam int NUM_MONTHS    = 12;

    localparam logic [24:0] COMMON_YEAR_SECS = 25'd31536000;
    localparam logic [24:0] LEAP_YEAR_SECS   = 25'd31622400;

    // Days before the first of each month in a common year.
    localparam logic [8:0] DAYS_BEFORE [NUM_MONTHS] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

endpackage

// File: hw/rtl/second_of_year_to_calendar.sv
// Top level of the second-of-year to calendar converter.
// Depends on soy2cal_pkg, soy2cal_div and soy2cal_month.

// The block turns a timestamp given as year, second within the year and
// microsecond into day of year, month, day of month, hour, minute and second.
// It is a five-stage pipeline that takes one item in every cycle when the
// output side does not stall; each item moves through stages 0 to 4 in
// order. The stages are set by the chain of constant divisions
// (by 60, by 60, by 24), each done as a reciprocal multiply with the
// remainder recovered in the stage after it, followed by two stages of month
// lookup. Every stage holds a valid bit, and a stage only loads when it is
// empty or the stage after it moves on, so a stall on the output fills the
// pipeline and then holds o_ready low without dropping or repeating any
// item. The leap rule is the Gregorian one for any year value. When the
// second count is not below the length of the year, invalid is set and the
// other fields are still computed by the same rules: the month stops at
// December and the day of month keeps only its low five bits. Year and
// microsecond pass through unchanged.
module second_of_year_to_calendar (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  soy2cal_pkg::t_in_item  i_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output soy2cal_pkg::t_out_item o_data
);
    import soy2cal_pkg::*;

    localparam int NSTG = 5;

    // Valid bits and the ready chain; rdy[k] means stage k may load.
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG:0]   rdy;

    always_comb begin
        rdy[NSTG] = i_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k + 1];
        end
    end

    always_comb begin
        for (int k = 0; k < NSTG; k++) begin
            if (rdy[k]) begin
                n_vld[k] = (k == 0) ? i_valid : r_vld[(k == 0) ? 0 : k - 1];
            end else begin
                n_vld[k] = r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_vld[NSTG-1];

    // Stage 0: total minutes and year divided by 25.
    logic [19:0] q_min;
    logic [9:0]  q_y25;
    logic [24:0] r0_secs;
    logic [13:0] r0_year;
    logic [19:0] r0_usec;

    soy2cal_div #(.N_W(25), .DIV(SECS_PER_MIN), .Q_W(20)) u_div_min (
        .i_clk (i_clk),
        .i_en  (rdy[0]),
        .i_num (i_data.second_of_year),
        .o_quo (q_min)
    );

    soy2cal_div #(.N_W(14), .DIV(LEAP_DIVISOR), .Q_W(10)) u_div_y25 (
        .i_clk (i_clk),
        .i_en  (rdy[0]),
        .i_num (i_data.year_in),
        .o_quo (q_y25)
    );

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r0_secs <= i_data.second_of_year;
            r0_year <= i_data.year_in;
            r0_usec <= i_data.microsecond_in;
        end
    end

    // Stage 1: second of minute, leap flag and total hours.
    // A year is leap when divisible by 4 and either not by 25 or also by 16.
    logic [24:0] min_x60;
    logic [14:0] y25_x25;
    logic        leap_s1;
    logic [13:0] q_hour;
    logic [5:0]  r1_sec;
    logic        r1_leap;
    logic [19:0] r1_min;
    logic [24:0] r1_secs;
    logic [13:0] r1_year;
    logic [19:0] r1_usec;

    assign min_x60 = 25'(q_min) * 25'(SECS_PER_MIN);
    assign y25_x25 = 15'(q_y25) * 15'(LEAP_DIVISOR);
    assign leap_s1 = (r0_year[1:0] == 2'd0)
                  && ((y25_x25 != 15'(r0_year)) || (r0_year[3:0] == 4'd0));

    soy2cal_div #(.N_W(20), .DIV(MINS_PER_HOUR), .Q_W(14)) u_div_hour (
        .i_clk (i_clk),
        .i_en  (rdy[1]),
        .i_num (q_min),
        .o_quo (q_hour)
    );

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r1_sec  <= 6'(r0_secs - min_x60);
            r1_leap <= leap_s1;
            r1_min  <= q_min;
            r1_secs <= r0_secs;
            r1_year <= r0_year;
            r1_usec <= r0_usec;
        end
    end

    // Stage 2: minute of hour, invalid flag and whole days.
    logic [19:0] hour_x60;
    logic [8:0]  q_day;
    logic [5:0]  r2_min;
    logic [5:0]  r2_sec;
    logic        r2_invalid;
    logic        r2_leap;
    logic [13:0] r2_hours;
    logic [13:0] r2_year;
    logic [19:0] r2_usec;

    assign hour_x60 = 20'(q_hour) * 20'(MINS_PER_HOUR);

    soy2cal_div #(.N_W(14), .DIV(HOURS_PER_DAY), .Q_W(9)) u_div_day (
        .i_clk (i_clk),
        .i_en  (rdy[2]),
        .i_num (q_hour),
        .o_quo (q_day)
    );

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r2_min     <= 6'(r1_min - hour_x60);
            r2_sec     <= r1_sec;
            r2_invalid <= r1_secs >= (r1_leap ? LEAP_YEAR_SECS : COMMON_YEAR_SECS);
            r2_leap    <= r1_leap;
            r2_hours   <= q_hour;
            r2_year    <= r1_year;
            r2_usec    <= r1_usec;
        end
    end

    // Stage 3: hour of day; the month lookup compares the day of year.
    logic [13:0] day_x24;
    logic [8:0]  doy_s3;
    t_mon_ctl    mon_ctl;
    logic [8:0]  doy_s4;
    logic [3:0]  month_s4;
    logic [4:0]  mday_s4;
    logic [4:0]  r3_hour;
    logic [5:0]  r3_min;
    logic [5:0]  r3_sec;
    logic        r3_invalid;
    logic [13:0] r3_year;
    logic [19:0] r3_usec;

    assign day_x24        = 14'(q_day) * 14'(HOURS_PER_DAY);
    assign doy_s3         = q_day + 9'd1;
    assign mon_ctl.cmp_en = rdy[3];
    assign mon_ctl.sel_en = rdy[4];

    soy2cal_month u_month (
        .i_clk   (i_clk),
        .i_ctl   (mon_ctl),
        .i_doy   (doy_s3),
        .i_leap  (r2_leap),
        .o_doy   (doy_s4),
        .o_month (month_s4),
        .o_mday  (mday_s4)
    );

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r3_hour    <= 5'(r2_hours - day_x24);
            r3_min     <= r2_min;
            r3_sec     <= r2_sec;
            r3_invalid <= r2_invalid;
            r3_year    <= r2_year;
            r3_usec    <= r2_usec;
        end
    end

    // Stage 4: the output register; month and day of month come from the lookup.
    logic [4:0]  r4_hour;
    logic [5:0]  r4_min;
    logic [5:0]  r4_sec;
    logic        r4_invalid;
    logic [13:0] r4_year;
    logic [19:0] r4_usec;

    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r4_hour    <= r3_hour;
            r4_min     <= r3_min;
            r4_sec     <= r3_sec;
            r4_invalid <= r3_invalid;
            r4_year    <= r3_year;
            r4_usec    <= r3_usec;
        end
    end

    assign o_data.year_out         = r4_year;
    assign o_data.day_of_year      = doy_s4;
    assign o_data.month_number     = month_s4;
    assign o_data.day_of_month     = mday_s4;
    assign o_data.hour_of_day      = r4_hour;
    assign o_data.minute_of_hour   = r4_min;
    assign o_data.second_of_minute = r4_sec;
    assign o_data.microsecond_out  = r4_usec;
    assign o_data.invalid          = r4_invalid;

    // The input side may only be held off when every stage holds an item.
    a_stall_only_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&r_vld))
        else $error("input stalled while the pipeline has an empty stage");

    // The month search always lands on January through December.
    a_month_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.month_number >= 4'd1) && (o_data.month_number <= 4'd12))
        else $error("month outside 1 to 12");

    // A second count inside the year gives a real date and time of day.
    a_valid_date : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.invalid |->
            (o_data.day_of_month != 5'd0) && (o_data.hour_of_day < 5'd24)
            && (o_data.day_of_year != 9'd0) && (o_data.day_of_year <= 9'd366))
        else $error("in-range timestamp gave an impossible date or hour");

endmodule

// File: hw/rtl/soy2cal_div.sv
// Registered unsigned division by a constant through a reciprocal multiply.
// Depends on nothing but its parameters.
module soy2cal_div #(
    parameter int N_W = 25,
    parameter int DIV = 60,
    parameter int Q_W = 20
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [N_W-1:0] i_num,
    output logic [Q_W-1:0] o_quo
);

    // The multiplier ceil(2^(N_W+L)/DIV) is exact for every N_W-bit dividend.
    localparam int          L_W    = $clog2(DIV);
    localparam int          SH     = N_W + L_W;
    localparam int          P_W    = 2 * N_W + 1;
    localparam logic [63:0] M_WIDE = ((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV);
    localparam logic [N_W:0] MULT  = M_WIDE[N_W:0];

    logic [P_W-1:0] prod;
    logic [Q_W-1:0] r_quo;

    assign prod = P_W'(i_num) * P_W'(MULT);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo <= prod[SH +: Q_W];
        end
    end

    assign o_quo = r_quo;

endmodule

// File: hw/rtl/soy2cal_month.sv
// Two-stage month lookup: threshold compares, then month and day of month.
// Depends on soy2cal_pkg for the days-before-month table.
module soy2cal_month (
    input  logic                  i_clk,
    input  soy2cal_pkg::t_mon_ctl i_ctl,
    input  logic [8:0]            i_doy,
    input  logic                  i_leap,
    output logic [8:0]            o_doy,
    output logic [3:0]            o_month,
    output logic [4:0]            o_mday
);
    import soy2cal_pkg::*;

    logic [NUM_MONTHS-2:0] n_gt;
    logic [NUM_MONTHS-2:0] r_gt;
    logic [8:0]            r_doy;
    logic                  r_leap;
    logic [3:0]            cnt;
    logic [8:0]            base;
    logic [8:0]            r_doy_o;
    logic [3:0]            r_month;
    logic [4:0]            r_mday;

    // Bit i is set when the day falls on or after the start of month i+2.
    always_comb begin
        for (int i = 0; i < NUM_MONTHS - 1; i++) begin
            n_gt[i] = i_doy > (DAYS_BEFORE[i + 1] + 9'((i >= 1) && i_leap));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_gt   <= n_gt;
            r_doy  <= i_doy;
            r_leap <= i_leap;
        end
    end

    // The thresholds rise, so the count of passed ones is the month index.
    assign cnt  = 4'($countones(r_gt));
    assign base = DAYS_BEFORE[cnt] + 9'((cnt >= 4'd2) && r_leap);

    always_ff @(posedge i_clk) begin
        if (i_ctl.sel_en) begin
            r_doy_o <= r_doy;
            r_month <= cnt + 4'd1;
            r_mday  <= 5'(r_doy - base);
        end
    end

    assign o_doy   = r_doy_o;
    assign o_month = r_month;
    assign o_mday  = r_mday;

endmodule
